@@ rtl/vr2d_pkg.sv @@
// Shared widths and payload types for the 2D vector reflection block.
// Used by vr2d_front, vr2d_div and vector_reflection_2d.
package vr2d_pkg;

   localparam int DW        = 16;            // field width, signed Q8.8
   localparam int PROD_W    = 2 * DW;        // one signed product
   localparam int DOT_W     = PROD_W + 1;    // sum of two products
   localparam int DMAG_W    = PROD_W;        // magnitude of the dot product
   localparam int DD_W      = PROD_W;        // squared length of the normal
   localparam int NUM_W     = DMAG_W + DW;   // numerator 2*|dot|*|n|
   localparam int QW        = DW + 2;        // quotient bits, |q| <= 2*|v|
   localparam int DIV_STEPS = QW;            // one quotient bit per stage
   localparam int RES_W     = DW + 4;        // headroom for v - q

   typedef struct packed {
      logic signed [DW-1:0] vel_x;
      logic signed [DW-1:0] vel_y;
      logic                 neg_x;   // sign of the x quotient term
      logic                 neg_y;   // sign of the y quotient term
      logic                 degen;   // normal is zero
   } side_type;

   typedef struct packed {
      logic              valid;
      side_type          side;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic [DD_W-1:0]   dd;
   } front_type;

endpackage

@@ rtl/vr2d_front.sv @@
// Front end of the reflection pipeline: products, dot product and squared
// length, then the scaled numerators. Three register stages. Uses vr2d_pkg.
module vr2d_front
   import vr2d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] vel_x,
   input  logic signed [DW-1:0] vel_y,
   input  logic signed [DW-1:0] norm_x,
   input  logic signed [DW-1:0] norm_y,
   output front_type            front_out
);

   // stage 1
   logic                     v1_ff, v1_in;
   logic signed [PROD_W-1:0] px_ff, py_ff, sx_ff, sy_ff;
   logic signed [PROD_W-1:0] px_in, py_in, sx_in, sy_in;
   logic [DW-1:0]            nmx_ff, nmy_ff, nmx_in, nmy_in;
   logic                     nnx_ff, nny_ff;
   logic signed [DW-1:0]     vx1_ff, vy1_ff;
   // stage 2
   logic                     v2_ff, v2_in;
   logic [DMAG_W-1:0]        dmag_ff, dmag_in;
   logic [DD_W-1:0]          dd2_ff, dd2_in;
   logic                     negx2_ff, negy2_ff, negx2_in, negy2_in;
   logic [DW-1:0]            nmx2_ff, nmy2_ff;
   logic signed [DW-1:0]     vx2_ff, vy2_ff;
   logic signed [DOT_W-1:0]  dot;
   // stage 3
   logic                     v3_ff, v3_in;
   logic [NUM_W-1:0]         numx_ff, numy_ff, numx_in, numy_in;
   logic [NUM_W-1:0]         prodx, prody;
   logic [DD_W-1:0]          dd3_ff;
   side_type                 side3_ff, side3_in;

   always_comb begin
      v1_in  = in_valid;
      px_in  = vel_x * norm_x;
      py_in  = vel_y * norm_y;
      sx_in  = norm_x * norm_x;
      sy_in  = norm_y * norm_y;
      nmx_in = norm_x[DW-1] ? DW'(-norm_x) : DW'(norm_x);
      nmy_in = norm_y[DW-1] ? DW'(-norm_y) : DW'(norm_y);

      v2_in    = v1_ff;
      dot      = DOT_W'(px_ff) + DOT_W'(py_ff);
      dmag_in  = dot[DOT_W-1] ? DMAG_W'(-dot) : DMAG_W'(dot);
      dd2_in   = DD_W'(sx_ff) + DD_W'(sy_ff);
      negx2_in = dot[DOT_W-1] ^ nnx_ff;
      negy2_in = dot[DOT_W-1] ^ nny_ff;

      v3_in    = v2_ff;
      prodx    = NUM_W'(dmag_ff) * NUM_W'(nmx2_ff);
      prody    = NUM_W'(dmag_ff) * NUM_W'(nmy2_ff);
      // The factor of two cannot overflow: the product is at most 2^46.
      numx_in  = {prodx[NUM_W-2:0], 1'b0};
      numy_in  = {prody[NUM_W-2:0], 1'b0};
      side3_in.vel_x = vx2_ff;
      side3_in.vel_y = vy2_ff;
      side3_in.neg_x = negx2_ff;
      side3_in.neg_y = negy2_ff;
      side3_in.degen = (dd2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         nmx_ff   <= nmx_in;
         nmy_ff   <= nmy_in;
         nnx_ff   <= norm_x[DW-1];
         nny_ff   <= norm_y[DW-1];
         vx1_ff   <= vel_x;
         vy1_ff   <= vel_y;
         dmag_ff  <= dmag_in;
         dd2_ff   <= dd2_in;
         negx2_ff <= negx2_in;
         negy2_ff <= negy2_in;
         nmx2_ff  <= nmx_ff;
         nmy2_ff  <= nmy_ff;
         vx2_ff   <= vx1_ff;
         vy2_ff   <= vy1_ff;
         numx_ff  <= numx_in;
         numy_ff  <= numy_in;
         dd3_ff   <= dd2_ff;
         side3_ff <= side3_in;
      end
   end

   always_comb begin
      front_out.valid = v3_ff;
      front_out.side  = side3_ff;
      front_out.num_x = numx_ff;
      front_out.num_y = numy_ff;
      front_out.dd    = dd3_ff;
   end

endmodule

@@ rtl/vr2d_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient is known to fit in QW bits. Uses vr2d_pkg.
module vr2d_div
   import vr2d_pkg::*;
(
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num,
   input  logic [DD_W-1:0]  den,
   output logic [QW-1:0]    quot
);

   logic [DD_W-1:0] rem_ff [DIV_STEPS];
   logic [QW-1:0]   low_ff [DIV_STEPS];
   logic [DD_W-1:0] den_ff [DIV_STEPS];
   logic [QW-1:0]   q_ff   [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [DD_W-1:0] rem_prev;
      logic [QW-1:0]   low_prev;
      logic [DD_W-1:0] den_prev;
      logic [QW-1:0]   q_prev;
      logic [DD_W:0]   trial;
      logic            fits;
      logic [DD_W-1:0] rem_in;
      logic [QW-1:0]   q_in;

      if (s == 0) begin : g_first
         // The upper numerator bits are below the divisor since q < 2^QW.
         assign rem_prev = DD_W'(num[NUM_W-1:QW]);
         assign low_prev = num[QW-1:0];
         assign den_prev = den;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign low_prev = low_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign q_prev   = q_ff[s-1];
      end

      always_comb begin
         trial  = {rem_prev, low_prev[QW-1-s]};
         fits   = (trial >= {1'b0, den_prev});
         rem_in = fits ? DD_W'(trial - {1'b0, den_prev}) : DD_W'(trial);
         q_in   = q_prev;
         q_in[QW-1-s] = fits;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            low_ff[s] <= low_prev;
            den_ff[s] <= den_prev;
            q_ff[s]   <= q_in;
         end
      end
   end

   assign quot = q_ff[DIV_STEPS-1];

endmodule

@@ rtl/vector_reflection_2d.sv @@
// Top level of the 2D vector reflection block: front end, two pipelined
// dividers and the saturating output stage. Uses vr2d_pkg, vr2d_front, vr2d_div.
//
// Usage:
//   The request channel (req_*) takes one velocity and one surface normal per
//   request; the response channel (rsp_*) returns the reflected velocity
//   r = v - 2*(v.d)/(d.d)*d with the quotient truncated toward zero, each
//   component clipped to 16 bits.
//   tuser bit 0 (degenerate) marks a zero normal, for which r = -v.
//   tuser bit 1 (saturated) marks a component clipped to range.
//   From request to response the pipeline has three front stages
//   (products, sums, numerator multiply), 18 divider stages with one
//   quotient bit each, and the output register.
//   Throughput is one request per cycle; the whole pipeline advances as
//   long as the output register is empty or being taken.
//   When the receiver stalls with a response waiting, every stage holds and
//   req_tready drops in the same cycle, so nothing is lost or repeated.
//   Reset clears all valid bits; the block is ready in the first cycle after.
module vector_reflection_2d
   import vr2d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [4*DW-1:0]     req_tdata,   // vel_x, vel_y, norm_x, norm_y
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [2*DW-1:0]     rsp_tdata,   // ref_x, ref_y
   output logic [1:0]          rsp_tuser    // degenerate, saturated
);

   localparam logic signed [RES_W-1:0] SMAX = RES_W'((1 << (DW-1)) - 1);
   localparam logic signed [RES_W-1:0] SMIN = -SMAX - RES_W'(1);

   logic       enable;
   front_type  front;
   logic [QW-1:0] qx, qy;

   logic     dv_ff   [DIV_STEPS];
   side_type side_ff [DIV_STEPS];

   logic                 out_valid_ff;
   logic signed [DW-1:0] refx_ff, refy_ff, refx_in, refy_in;
   logic                 degen_ff, sat_ff, sat_in;

   assign enable     = !out_valid_ff || rsp_tready;
   assign req_tready = enable;

   vr2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .vel_x     (req_tdata[DW-1:0]),
      .vel_y     (req_tdata[2*DW-1:DW]),
      .norm_x    (req_tdata[3*DW-1:2*DW]),
      .norm_y    (req_tdata[4*DW-1:3*DW]),
      .front_out (front)
   );

   vr2d_div u_div_x (
      .clock  (clock),
      .enable (enable),
      .num    (front.num_x),
      .den    (front.dd),
      .quot   (qx)
   );

   vr2d_div u_div_y (
      .clock  (clock),
      .enable (enable),
      .num    (front.num_y),
      .den    (front.dd),
      .quot   (qy)
   );

   // Side information travels beside the divider stages.
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (enable) begin
            dv_ff[s] <= (s == 0) ? front.valid : dv_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[s] <= (s == 0) ? front.side : side_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   always_comb begin
      side_type          sd;
      logic signed [RES_W-1:0] vx, vy, tx, ty, rx, ry;
      sd = side_ff[DIV_STEPS-1];
      vx = RES_W'(sd.vel_x);
      vy = RES_W'(sd.vel_y);
      tx = sd.neg_x ? -RES_W'(qx) : RES_W'(qx);
      ty = sd.neg_y ? -RES_W'(qy) : RES_W'(qy);
      rx = sd.degen ? -vx : vx - tx;
      ry = sd.degen ? -vy : vy - ty;
      sat_in = 1'b0;
      if (rx > SMAX) begin
         refx_in = DW'(SMAX);
         sat_in  = 1'b1;
      end else if (rx < SMIN) begin
         refx_in = DW'(SMIN);
         sat_in  = 1'b1;
      end else begin
         refx_in = DW'(rx);
      end
      if (ry > SMAX) begin
         refy_in = DW'(SMAX);
         sat_in  = 1'b1;
      end else if (ry < SMIN) begin
         refy_in = DW'(SMIN);
         sat_in  = 1'b1;
      end else begin
         refy_in = DW'(ry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= dv_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         refx_ff  <= refx_in;
         refy_ff  <= refy_in;
         degen_ff <= side_ff[DIV_STEPS-1].degen;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {refy_ff, refx_ff};
   assign rsp_tuser  = {sat_ff, degen_ff};

   // The pipeline only holds while a response is waiting.
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("pipeline stalled without a blocked response");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // A saturated response has a component at one of the bounds.
   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (refx_ff == DW'(SMAX) || refx_ff == DW'(SMIN) ||
          refy_ff == DW'(SMAX) || refy_ff == DW'(SMIN)))
      else $error("saturated flag without a clipped component");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for vector_reflection_2d: directed table, then random requests,
// checked against a predictor of the reflection. Depends on vr2d_pkg and the RTL.
module tb;
   import vr2d_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [4*DW-1:0] req_tdata;
   logic [2*DW-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   typedef struct packed {
      logic signed [DW-1:0] ref_x;
      logic signed [DW-1:0] ref_y;
      logic degen;
      logic sat;
   } bounce_type;

   typedef struct {
      logic [4*DW-1:0] data;
      logic known;        // row carries a typed-in result
      bounce_type res;
   } row_type;

   localparam int NUM_RANDOM = 650;
   localparam int LATENCY = 22;

   bounce_type bounce_q[$];
   row_type rows[$];
   int errors = 0;
   bit sending_done = 0;
   int hold_long = 0;
   int sent = 0;

   vector_reflection_2d u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic longint clamp(longint x, ref bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
         sat = 1;
         return hi;
      end
      if (x < lo) begin
         sat = 1;
         return lo;
      end
      return x;
   endfunction

   // Quotients are truncated toward zero; 128-bit math keeps 2*dot*n exact.
   function automatic bounce_type reflect(logic [4*DW-1:0] d);
      longint vx, vy, nx, ny, dot, dd, rx, ry;
      logic signed [127:0] px, py;
      bit sat;
      bounce_type b;
      vx = longint'($signed(d[DW-1:0]));
      vy = longint'($signed(d[2*DW-1:DW]));
      nx = longint'($signed(d[3*DW-1:2*DW]));
      ny = longint'($signed(d[4*DW-1:3*DW]));
      dd = nx * nx + ny * ny;
      dot = vx * nx + vy * ny;
      sat = 0;
      b.degen = (dd == 0);
      if (dd == 0) begin
         rx = -vx;
         ry = -vy;
      end else begin
         px = 128'(2 * dot) * 128'(nx);
         py = 128'(2 * dot) * 128'(ny);
         rx = vx - longint'(px / 128'(dd));
         ry = vy - longint'(py / 128'(dd));
      end
      b.ref_x = DW'(clamp(rx, sat));
      b.ref_y = DW'(clamp(ry, sat));
      b.sat = sat;
      return b;
   endfunction

   function automatic logic [4*DW-1:0] pack_req(int vx, int vy, int nx, int ny);
      return {DW'(ny), DW'(nx), DW'(vy), DW'(vx)};
   endfunction

   task automatic add_row(int vx, int vy, int nx, int ny, bit known = 0,
                          int rx = 0, int ry = 0, bit dg = 0, bit st = 0);
      row_type r;
      r.data = pack_req(vx, vy, nx, ny);
      r.known = known;
      r.res = '{DW'(rx), DW'(ry), dg, st};
      rows.push_back(r);
   endtask

   function automatic int rand_field();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return int'($urandom_range(0, 1024)) - 512;
         2: return 0;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Sender: the directed table first, then random requests.
   initial begin
      logic [4*DW-1:0] d;
      int k;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      add_row(0, 0, 0, 0, 1, 0, 0, 1, 0);
      add_row(256, -512, 0, 0, 1, -256, 512, 1, 0);
      add_row(-32768, -32768, 0, 0, 1, 32767, 32767, 1, 1);
      add_row(32767, -32768, 0, 0, 1, -32767, 32767, 1, 1);
      add_row(256, 0, 256, 0, 1, -256, 0, 0, 0);
      add_row(0, 256, 256, 0, 1, 0, 256, 0, 0);
      add_row(300, 400, 0, 1, 1, 300, -400, 0, 0);
      add_row(32767, 32767, 1, 1);
      add_row(-32768, -32768, -32768, -32768);
      add_row(32767, -32768, -32768, 32767);
      add_row(-32768, 32767, 32767, 1);
      add_row(32767, 32767, -32768, 0);
      add_row(-32768, 0, 32767, 0);
      add_row(100, 200, 3, 7);
      add_row(-100, 200, -3, 7);
      add_row(12345, -23456, 1, -32768);
      add_row(-1, -1, 32767, 32767);
      add_row(1, 0, 1, 1);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      k = 0;
      while (k < rows.size() + NUM_RANDOM) begin
         if (k < rows.size()) d = rows[k].data;
         else d = pack_req(rand_field(), rand_field(), rand_field(), rand_field());
         // Go idle at random with a 7 percent chance, except during a quiet stretch.
         if (!(k > 300 && k < 420) && $urandom_range(0, 99) < 7) begin
            req_tvalid <= 0;
            @(negedge clock);
            continue;
         end
         req_tvalid <= 1;
         req_tdata <= d;
         // Ready is stable from shortly after the falling edge to the rising edge.
         #1;
         while (!req_tready) begin
            @(negedge clock);
            #1;
         end
         @(posedge clock);
         if (k < rows.size() && rows[k].known) bounce_q.push_back(rows[k].res);
         else bounce_q.push_back(reflect(d));
         if (k < rows.size() && rows[k].known && reflect(d) != rows[k].res) begin
            $error("table row %0d disagrees with predictor", k);
            errors++;
         end
         k++;
         sent++;
         @(negedge clock);
      end
      req_tvalid <= 0;
      sending_done = 1;
   end

   // Receiver with random stalls and one long hold-off.
   initial begin
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long == 0 && sent > 200) begin
            hold_long = 1;
            rsp_tready <= 0;
            repeat (150) @(negedge clock);
         end
         rsp_tready <= (sent > 450 && sent < 600) || ($urandom_range(0, 99) >= 7);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      bounce_type e, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[DW-1:0], rsp_tdata[2*DW-1:DW], rsp_tuser[0], rsp_tuser[1]};
         if (bounce_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = bounce_q.pop_front();
            if (got.ref_x !== e.ref_x) begin
               $error("ref_x expected %0d actual %0d", e.ref_x, got.ref_x);
               errors++;
            end
            if (got.ref_y !== e.ref_y) begin
               $error("ref_y expected %0d actual %0d", e.ref_y, got.ref_y);
               errors++;
            end
            if (got.degen !== e.degen) begin
               $error("degenerate expected %0b actual %0b", e.degen, got.degen);
               errors++;
            end
            if (got.sat !== e.sat) begin
               $error("saturated expected %0b actual %0b", e.sat, got.sat);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      while (bounce_q.size() != 0) @(posedge clock);
      repeat (LATENCY * 3) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
